// ----- hdl/isd_pkg.sv -----
// ----------------------------------------------------------------------------
// isd_pkg
// Shared types and constants of the imu shake detector.
// ----------------------------------------------------------------------------
package isd_pkg;

   // low bits of each sample field that carry the value, sign-extended from there
   localparam int SAMPLE_WIDTH = 16;

   localparam logic [15:0] ONE_G = 16'd8192;

   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENABLE       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COOLDOWN     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELTA_THR    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHANGE_THR   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GYRO_THR     = 3'd4;

   localparam logic [15:0] COOLDOWN_RESET   = 16'd500;
   localparam logic [15:0] DELTA_THR_RESET  = 16'd4096;
   localparam logic [15:0] CHANGE_THR_RESET = 16'd4096;
   localparam logic [15:0] GYRO_THR_RESET   = 16'd16384;

   // multiplier operand order: three accel squares, three gyro squares, threshold square
   localparam int NUM_PRODUCTS = 7;
   localparam logic [2:0] LAST_PRODUCT = 3'd6;
   localparam logic [2:0] LAST_ACCEL   = 3'd2;
   localparam logic [2:0] LAST_GYRO    = 3'd5;
   localparam logic [3:0] SQUARE_LAST  = 4'd7;
   localparam logic [3:0] ROOT_LAST    = 4'd15;

   typedef struct packed {
      logic        enable;
      logic [15:0] cooldown_ms;
      logic [15:0] accel_delta_threshold;
      logic [15:0] accel_change_threshold;
      logic [15:0] gyro_threshold;
   } cfg_type;

   typedef struct packed {
      logic       capture;
      logic       mul_en;
      logic [2:0] mul_sel;
      logic       acc_en;
      logic [2:0] acc_sel;
      logic       root_init;
      logic       root_en;
      logic       load_out;
   } cmd_type;

endpackage

// ----- hdl/isd_ctrl.sv -----
// ----------------------------------------------------------------------------
// isd_ctrl
// Sequencer: capture, squaring steps, square-root steps, result load.
// ----------------------------------------------------------------------------
module isd_ctrl
   import isd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    enable,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SQUARE = 4'b0010,
      S_ROOT   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.capture   = accept;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = enable ? S_SQUARE : S_FINISH;
            end
         end
         S_SQUARE: begin
            // product of step n is accumulated in step n+1
            cmd.mul_en  = (cnt_ff[2:0] <= LAST_PRODUCT);
            cmd.mul_sel = cnt_ff[2:0];
            cmd.acc_en  = (cnt_ff != '0);
            cmd.acc_sel = cnt_ff[2:0] - 3'd1;
            cnt_in      = cnt_ff + 4'd1;
            if (cnt_ff == SQUARE_LAST) begin
               cmd.root_init = 1'b1;
               cnt_in        = '0;
               state_in      = S_ROOT;
            end
         end
         S_ROOT: begin
            cmd.root_en = 1'b1;
            cnt_in      = cnt_ff + 4'd1;
            if (cnt_ff == ROOT_LAST) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hdl/isd_dp.sv -----
// ----------------------------------------------------------------------------
// isd_dp
// Datapath: sample registers, shared multiplier, bit-pair square root,
// threshold tests, detector state and result register.
// ----------------------------------------------------------------------------
module isd_dp
   import isd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  cmd_type     cmd,
   input  logic [15:0] req_accel_x,
   input  logic [15:0] req_accel_y,
   input  logic [15:0] req_accel_z,
   input  logic [15:0] req_gyro_x,
   input  logic [15:0] req_gyro_y,
   input  logic [15:0] req_gyro_z,
   input  logic [31:0] req_now_ms,
   output logic        rsp_shake,
   output logic        rsp_strong_accel,
   output logic        rsp_strong_gyro,
   output logic        rsp_cooling_down,
   output logic [15:0] rsp_accel_magnitude
);

   function automatic logic [15:0] sample_abs(input logic [15:0] raw);
      logic signed [16:0] v;
      logic        [16:0] m;
      v = signed'({{(17 - SAMPLE_WIDTH){raw[SAMPLE_WIDTH-1]}}, raw[SAMPLE_WIDTH-1:0]});
      m = v[16] ? 17'(-v) : 17'(v);
      return m[15:0];
   endfunction

   logic [15:0] smp_ff [NUM_PRODUCTS-1];
   logic [31:0] now_ff;

   logic [15:0] mul_op;
   logic [31:0] prod_ff;
   logic [31:0] asum_ff, gsum_ff, gthr_ff;

   logic [31:0] x_ff, root_ff, bit_ff;
   logic [32:0] trial;

   logic [15:0] prev_mag_ff;
   logic        have_ff;
   logic [31:0] last_ff;

   logic [15:0] mag;
   logic [15:0] delta, change, prev_diff;
   logic [31:0] elapsed;
   logic        strong_accel, strong_gyro, cooling, shake;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         smp_ff[0] <= sample_abs(req_accel_x);
         smp_ff[1] <= sample_abs(req_accel_y);
         smp_ff[2] <= sample_abs(req_accel_z);
         smp_ff[3] <= sample_abs(req_gyro_x);
         smp_ff[4] <= sample_abs(req_gyro_y);
         smp_ff[5] <= sample_abs(req_gyro_z);
         now_ff    <= req_now_ms;
      end
   end

   // one 16x16 multiplier serves all seven squares
   always_comb begin
      if (cmd.mul_sel == LAST_PRODUCT) begin
         mul_op = cfg.gyro_threshold;
      end else begin
         mul_op = smp_ff[cmd.mul_sel];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= 32'(mul_op) * 32'(mul_op);
      end
      if (cmd.capture) begin
         asum_ff <= '0;
         gsum_ff <= '0;
      end else if (cmd.acc_en) begin
         if (cmd.acc_sel <= LAST_ACCEL) begin
            asum_ff <= asum_ff + prod_ff;
         end else if (cmd.acc_sel <= LAST_GYRO) begin
            gsum_ff <= gsum_ff + prod_ff;
         end else begin
            gthr_ff <= prod_ff;
         end
      end
   end

   // floor square root, two radicand bits per step
   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         x_ff    <= asum_ff;
         root_ff <= '0;
         bit_ff  <= 32'h4000_0000;
      end else if (cmd.root_en) begin
         if ({1'b0, x_ff} >= trial) begin
            x_ff    <= x_ff - trial[31:0];
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign mag       = root_ff[15:0];
   assign delta     = (mag > ONE_G) ? (mag - ONE_G) : (ONE_G - mag);
   assign prev_diff = (mag > prev_mag_ff) ? (mag - prev_mag_ff) : (prev_mag_ff - mag);
   assign change    = have_ff ? prev_diff : '0;
   assign elapsed   = now_ff - last_ff;

   assign strong_accel = (delta > cfg.accel_delta_threshold) ||
                         (change > cfg.accel_change_threshold);
   assign strong_gyro  = gsum_ff > gthr_ff;
   assign cooling      = elapsed < {16'd0, cfg.cooldown_ms};
   assign shake        = !cooling && (strong_accel || strong_gyro);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mag_ff <= ONE_G;
         have_ff     <= 1'b0;
         last_ff     <= '0;
      end else if (cmd.load_out && cfg.enable) begin
         prev_mag_ff <= mag;
         have_ff     <= 1'b1;
         if (shake) begin
            last_ff <= now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_shake           <= cfg.enable && shake;
         rsp_strong_accel    <= cfg.enable && strong_accel;
         rsp_strong_gyro     <= cfg.enable && strong_gyro;
         rsp_cooling_down    <= cfg.enable && cooling;
         rsp_accel_magnitude <= cfg.enable ? mag : '0;
      end
   end

endmodule

// ----- hdl/imu_shake_detector.sv -----
// ----------------------------------------------------------------------------
// imu_shake_detector
// Shake detector for six-axis IMU samples with cooldown after each shake.
// ----------------------------------------------------------------------------
// An enabled sample runs through the squaring steps on the single shared
// 16x16 multiplier (six squares plus the gyro threshold square, each product
// summed in the step after it is formed), the two-bits-per-step square-root
// unit, a finish state that tests and loads the result register, and the idle
// state in which the next sample is taken. While enable is clear a sample
// goes straight to the finish state and returns an all-zero result. A new
// sample is accepted while the previous result still waits in the output
// register; its own result then holds in the finish state until that
// register frees. Every sample yields exactly one result beat.
// csr_ready is always high.
module imu_shake_detector
   import isd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [15:0]                req_accel_x,
   input  logic [15:0]                req_accel_y,
   input  logic [15:0]                req_accel_z,
   input  logic [15:0]                req_gyro_x,
   input  logic [15:0]                req_gyro_y,
   input  logic [15:0]                req_gyro_z,
   input  logic [31:0]                req_now_ms,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_shake,
   output logic                       rsp_strong_accel,
   output logic                       rsp_strong_gyro,
   output logic                       rsp_cooling_down,
   output logic [15:0]                rsp_accel_magnitude,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                csr_data
);

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE:     cfg_in.enable                 = csr_data[0];
            CSR_COOLDOWN:   cfg_in.cooldown_ms            = csr_data;
            CSR_DELTA_THR:  cfg_in.accel_delta_threshold  = csr_data;
            CSR_CHANGE_THR: cfg_in.accel_change_threshold = csr_data;
            CSR_GYRO_THR:   cfg_in.gyro_threshold         = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable                 <= 1'b0;
         cfg_ff.cooldown_ms            <= COOLDOWN_RESET;
         cfg_ff.accel_delta_threshold  <= DELTA_THR_RESET;
         cfg_ff.accel_change_threshold <= CHANGE_THR_RESET;
         cfg_ff.gyro_threshold         <= GYRO_THR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   isd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .enable    (cfg_ff.enable),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   isd_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .cmd                 (cmd),
      .req_accel_x         (req_accel_x),
      .req_accel_y         (req_accel_y),
      .req_accel_z         (req_accel_z),
      .req_gyro_x          (req_gyro_x),
      .req_gyro_y          (req_gyro_y),
      .req_gyro_z          (req_gyro_z),
      .req_now_ms          (req_now_ms),
      .rsp_shake           (rsp_shake),
      .rsp_strong_accel    (rsp_strong_accel),
      .rsp_strong_gyro     (rsp_strong_gyro),
      .rsp_cooling_down    (rsp_cooling_down),
      .rsp_accel_magnitude (rsp_accel_magnitude)
   );

`ifndef ASSERT_OFF
   // an accepted beat keeps the input side busy in the cycle after it
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted again right after a beat");

   // a shake needs a passing test outside the cooldown window
   a_shake_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shake |-> (rsp_strong_accel || rsp_strong_gyro) && !rsp_cooling_down)
      else $error("shake reported without cause or inside cooldown");

   // result register loads only when empty or drained on the same edge
   a_load_needs_free_out: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !rsp_valid || !rsp_stall)
      else $error("result register overwritten while held");
`endif

endmodule

// ----- verif/shake_checker.sv -----
// ----------------------------------------------------------------------------
// shake_checker
// Watches the sample, result and register channels of the shake detector,
// predicts every result beat from its own copy of the registers and detector
// state, and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shake_checker
   import isd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [15:0]                req_accel_x,
   input  logic [15:0]                req_accel_y,
   input  logic [15:0]                req_accel_z,
   input  logic [15:0]                req_gyro_x,
   input  logic [15:0]                req_gyro_y,
   input  logic [15:0]                req_gyro_z,
   input  logic [31:0]                req_now_ms,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_shake,
   input  logic                       rsp_strong_accel,
   input  logic                       rsp_strong_gyro,
   input  logic                       rsp_cooling_down,
   input  logic [15:0]                rsp_accel_magnitude,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                csr_data,
   output int                         fail_count,
   output int                         results_seen,
   output int                         pending,
   output int                         shake_count
);

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic        shake;
      logic        strong_accel;
      logic        strong_gyro;
      logic        cooling_down;
      logic [15:0] magnitude;
   } shake_result_type;

   cfg_type          settings;
   logic [16:0]      prev_mag;
   logic             seen_sample;
   logic [31:0]      last_shake_ms;
   shake_result_type expected_q[$];

   function automatic longint unsigned axis_square(input logic [15:0] raw);
      longint v;
      v = longint'($signed(raw));
      return longint'(v * v);
   endfunction

   always @(posedge clock) begin : track
      longint unsigned  accel_sq, gyro_sq, gyro_lim, trial;
      logic [16:0]      root, deviation, change;
      logic [31:0]      elapsed;
      logic             hit_accel, hit_gyro, cooling, fire;
      shake_result_type want, got;
      int               bit_pos;
      if (reset) begin
         settings = '{enable: 1'b0, cooldown_ms: COOLDOWN_RESET,
                      accel_delta_threshold: DELTA_THR_RESET,
                      accel_change_threshold: CHANGE_THR_RESET,
                      gyro_threshold: GYRO_THR_RESET};
         prev_mag = 17'(ONE_G);
         seen_sample = 1'b0;
         last_shake_ms = '0;
         expected_q.delete();
         fail_count <= 0;
         results_seen <= 0;
         pending <= 0;
         shake_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE:     settings.enable = csr_data[0];
               CSR_COOLDOWN:   settings.cooldown_ms = csr_data;
               CSR_DELTA_THR:  settings.accel_delta_threshold = csr_data;
               CSR_CHANGE_THR: settings.accel_change_threshold = csr_data;
               CSR_GYRO_THR:   settings.gyro_threshold = csr_data;
               default: ;
            endcase
         end

         // result beats first: a sample accepted on this edge cannot answer here
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_shake, rsp_strong_accel, rsp_strong_gyro, rsp_cooling_down,
                    rsp_accel_magnitude};
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0) begin
               if (fail_count < MAX_REPORTS)
                  $display("%0t: result beat with nothing expected: shake %0b accel %0b",
                           $realtime, got.shake, got.strong_accel,
                           " gyro %0b cool %0b mag %0d",
                           got.strong_gyro, got.cooling_down, got.magnitude);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got.shake !== want.shake || got.strong_accel !== want.strong_accel ||
                   got.strong_gyro !== want.strong_gyro ||
                   got.cooling_down !== want.cooling_down ||
                   got.magnitude !== want.magnitude) begin
                  if (fail_count < MAX_REPORTS) begin
                     $display("%0t: result %0d expected shake %0b accel %0b gyro %0b",
                              $realtime, results_seen, want.shake, want.strong_accel,
                              want.strong_gyro, " cool %0b mag %0d",
                              want.cooling_down, want.magnitude);
                     $display("%0t: result %0d got      shake %0b accel %0b gyro %0b",
                              $realtime, results_seen, got.shake, got.strong_accel,
                              got.strong_gyro, " cool %0b mag %0d",
                              got.cooling_down, got.magnitude);
                  end
                  fail_count <= fail_count + 1;
               end else if (want.shake) begin
                  shake_count <= shake_count + 1;
               end
            end
         end

         if (req_valid && !req_stall) begin
            want = '0;
            if (settings.enable) begin
               accel_sq = axis_square(req_accel_x) + axis_square(req_accel_y) +
                          axis_square(req_accel_z);
               gyro_sq = axis_square(req_gyro_x) + axis_square(req_gyro_y) +
                         axis_square(req_gyro_z);
               // floor square root, one result bit per step from the top
               root = '0;
               for (bit_pos = 16; bit_pos >= 0; bit_pos--) begin
                  trial = longint'(root) | (64'd1 << bit_pos);
                  if (trial * trial <= accel_sq)
                     root = 17'(trial);
               end
               deviation = (root > ONE_G) ? root - ONE_G : ONE_G - root;
               if (!seen_sample)
                  change = '0;
               else
                  change = (root > prev_mag) ? root - prev_mag : prev_mag - root;
               prev_mag = root;
               seen_sample = 1'b1;
               gyro_lim = longint'(settings.gyro_threshold) * settings.gyro_threshold;
               hit_accel = deviation > settings.accel_delta_threshold ||
                           change > settings.accel_change_threshold;
               hit_gyro = gyro_sq > gyro_lim;
               elapsed = req_now_ms - last_shake_ms;
               cooling = elapsed < settings.cooldown_ms;
               fire = !cooling && (hit_accel || hit_gyro);
               if (fire)
                  last_shake_ms = req_now_ms;
               want = '{fire, hit_accel, hit_gyro, cooling, root[15:0]};
            end
            expected_q.push_back(want);
         end
         pending <= expected_q.size();
      end
   end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives the shake detector with directed corner samples and random motion
// under several register settings and idle patterns, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
   import isd_pkg::*;
();

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_CYCLES     = 300;
   localparam int CSR_SPARE_FIRST = int'(CSR_GYRO_THR) + 1;
   localparam int CSR_SPARE_LAST  = 2 ** CSR_INDEX_WIDTH - 1;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [15:0]                req_accel_x = '0;
   logic [15:0]                req_accel_y = '0;
   logic [15:0]                req_accel_z = '0;
   logic [15:0]                req_gyro_x = '0;
   logic [15:0]                req_gyro_y = '0;
   logic [15:0]                req_gyro_z = '0;
   logic [31:0]                req_now_ms = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_shake;
   logic                       rsp_strong_accel;
   logic                       rsp_strong_gyro;
   logic                       rsp_cooling_down;
   logic [15:0]                rsp_accel_magnitude;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [15:0]                csr_data = '0;

   int fail_count;
   int results_seen;
   int pending;
   int shake_count;

   int          items_sent = 0;
   int          settings_used = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          cur_cooldown = 500;
   int          cur_delta = 4096;
   int          cur_gyro = 16384;
   logic [31:0] stamp_ms = '0;
   logic        hold_go = 1'b0;
   int          hold_count = 0;
   int          cycle_count = 0;

   imu_shake_detector dut (.*);

   shake_checker u_check (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles with %0d results outstanding",
                  cycle_count, items_sent - results_seen);
         $display("imu_shake_detector: mismatch");
         $finish;
      end
   end

   // receiver: random stall, or a long hold-off counted here while hold_go is up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_count <= 0;
      end else if (hold_go && hold_count < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= $urandom_range(0, 99) < stall_pct;
         if (!hold_go)
            hold_count <= 0;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic [15:0] ax, ay, az, gx, gy, gz,
                              input logic [31:0] stamp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_accel_z <= az;
      req_gyro_x <= gx;
      req_gyro_y <= gy;
      req_gyro_z <= gz;
      req_now_ms <= stamp;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // stop offering, wait for every result beat, then let the datapath settle
   task automatic drain();
      req_valid <= 1'b0;
      while (results_seen < items_sent)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_motion();
      int unsigned pick, lead;
      logic [15:0] ax, ay, az, gx, gy, gz, level;
      ax = 16'($urandom_range(0, 800) - 400);
      ay = 16'($urandom_range(0, 800) - 400);
      az = 16'($urandom_range(0, 800) - 400);
      gx = 16'($urandom_range(0, 3000) - 1500);
      gy = 16'($urandom_range(0, 3000) - 1500);
      gz = 16'($urandom_range(0, 3000) - 1500);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         // at rest: gravity on one axis, some noise elsewhere
         level = 16'(ONE_G + $urandom_range(0, 800) - 400);
         if ($urandom_range(0, 1))
            level = -level;
         lead = $urandom_range(0, 2);
         if (lead == 0)
            ax = level;
         else if (lead == 1)
            ay = level;
         else
            az = level;
      end else if (pick < 45) begin
         // magnitude right at the deviation limit
         ax = '0;
         ay = '0;
         az = 16'(($urandom_range(0, 1) ? ONE_G + cur_delta : ONE_G - cur_delta) +
                  $urandom_range(0, 3) - 1);
      end else if (pick < 55) begin
         // spin right at the gyro limit on one axis
         level = 16'(cur_gyro + $urandom_range(0, 2) - 1);
         gx = $urandom_range(0, 1) ? level : -level;
         gy = '0;
         gz = '0;
         ax = '0;
         ay = '0;
         az = ONE_G;
      end else if (pick < 80) begin
         ax = 16'($urandom);
         ay = 16'($urandom);
         az = 16'($urandom);
         gx = 16'($urandom_range(0, 20000) - 10000);
         gy = 16'($urandom_range(0, 20000) - 10000);
         gz = 16'($urandom_range(0, 20000) - 10000);
      end else begin
         ax = 16'($urandom);
         ay = 16'($urandom);
         az = 16'($urandom);
         gx = 16'($urandom);
         gy = 16'($urandom);
         gz = 16'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 85)
         stamp_ms += $urandom_range(0, 60);
      else if (pick < 95)
         stamp_ms += $urandom_range(0, cur_cooldown + 20);
      else
         stamp_ms = $urandom;
      send_sample(ax, ay, az, gx, gy, gz, stamp_ms);
   endtask

   task automatic run_phase(input int cooldown, delta, change, gyro, input logic en,
                            input int idle, stall, count);
      drain();
      write_reg(CSR_COOLDOWN, 16'(cooldown));
      write_reg(CSR_DELTA_THR, 16'(delta));
      write_reg(CSR_CHANGE_THR, 16'(change));
      write_reg(CSR_GYRO_THR, 16'(gyro));
      write_reg(CSR_ENABLE, {15'($urandom), en});
      write_reg(CSR_INDEX_WIDTH'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                16'($urandom));
      cur_cooldown = cooldown;
      cur_delta = delta;
      cur_gyro = gyro;
      settings_used++;
      send_idle_pct = idle;
      stall_pct <= stall;
      stamp_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 2000);
      repeat (count) send_motion();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled after reset: all-zero result, no state change
      send_sample(-32768, -32768, -32768, 32767, 32767, 32767, 32'd0);
      drain();
      write_reg(CSR_CHANGE_THR, 16'd0);
      write_reg(CSR_ENABLE, {15'($urandom), 1'b1});
      settings_used++;
      // first sample takes no change; reset cooldown and thresholds otherwise
      send_sample(0, 0, 9000, 0, 0, 0, 32'd0);
      send_sample(0, 0, 9000, 16384, 0, 0, 32'd10);
      send_sample(0, 0, 9001, 16385, 0, 0, 32'd20);
      send_sample(-32768, -32768, -32768, 0, 0, 0, 32'd499);
      send_sample(0, 0, 0, 0, 0, 0, 32'd500);
      send_sample(0, 0, 8192, 0, 0, 0, 32'd999);
      send_sample(0, 0, 8192, 0, 0, 0, 32'd1000);
      send_sample(32767, 32767, 32767, -32768, -32768, -32768, 32'd1001);

      // zero thresholds: any nonzero excess passes, no cooldown at all
      drain();
      write_reg(CSR_COOLDOWN, 16'd0);
      write_reg(CSR_DELTA_THR, 16'd0);
      write_reg(CSR_CHANGE_THR, 16'd0);
      write_reg(CSR_GYRO_THR, 16'd0);
      settings_used++;
      send_sample(8192, 0, 0, 0, 0, 0, 32'd5);
      send_sample(0, -8192, 0, 0, 0, 0, 32'd6);
      send_sample(0, 0, 8192, 1, 0, 0, 32'd7);
      send_sample(0, 0, -8193, 0, 0, 0, 32'd8);

      // widest cooldown, change and gyro limits, with the timestamp wrapping
      drain();
      write_reg(CSR_COOLDOWN, 16'hFFFF);
      write_reg(CSR_DELTA_THR, 16'd10);
      write_reg(CSR_CHANGE_THR, 16'hFFFF);
      write_reg(CSR_GYRO_THR, 16'hFFFF);
      settings_used++;
      send_sample(0, 0, 0, 32767, -32768, 32767, 32'hFFFF_FF00);
      send_sample(0, 0, 0, 0, 0, 0, 32'h0000_0010);
      send_sample(0, 0, 0, 0, 0, 0, 32'h0000_FEFE);
      send_sample(0, 0, 0, 0, 0, 0, 32'h0000_FEFF);

      // a disabled beat in between must leave the shake time alone
      drain();
      write_reg(CSR_ENABLE, {15'($urandom), 1'b0});
      send_sample(0, 0, 0, 0, 0, 0, 32'h8000_0000);
      drain();
      write_reg(CSR_ENABLE, {15'($urandom), 1'b1});
      write_reg(CSR_INDEX_WIDTH'(CSR_SPARE_LAST), 16'hFFFF);
      write_reg(CSR_INDEX_WIDTH'(CSR_SPARE_FIRST), 16'h0000);
      send_sample(0, 0, 8192, 0, 0, 0, 32'h0000_FF63);

      run_phase(COOLDOWN_RESET, DELTA_THR_RESET, CHANGE_THR_RESET, GYRO_THR_RESET, 1'b1,
                0, 0, 95);
      run_phase(0, 0, 0, 0, 1'b1, 55, 0, 95);
      run_phase(65535, 65535, 65535, 65535, 1'b1, 0, 55, 95);
      run_phase(100, 2000, 1500, 8000, 1'b1, 27, 27, 95);
      run_phase($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b1, 0, 0, 95);
      run_phase(40, 6000, 3000, 20000, 1'b1, 55, 0, 95);
      run_phase($urandom_range(0, 1000), $urandom_range(0, 10000),
                $urandom_range(0, 10000), $urandom_range(0, 30000), 1'b1, 0, 55, 95);
      run_phase($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b0, 27, 27, 40);
      run_phase($urandom_range(0, 1000), $urandom_range(0, 10000),
                $urandom_range(0, 10000), $urandom_range(0, 30000), 1'b1, 27, 27, 95);

      // back-pressure: receiver holds off while samples keep coming
      run_phase(200, 3000, 2500, 12000, 1'b1, 0, 0, 0);
      hold_go <= 1'b1;
      repeat (50) send_motion();
      hold_go <= 1'b0;

      drain();
      if (pending != 0)
         $display("%0d expected results never arrived", pending);
      $display("%0d samples under %0d register settings, %0d result beats compared",
               items_sent, settings_used, results_seen);
      $display("%0d shakes seen, one %0d-cycle receiver hold-off backed up the input",
               shake_count, HOLD_CYCLES);
      if (fail_count == 0 && pending == 0)
         $display("imu_shake_detector: match");
      else
         $display("imu_shake_detector: mismatch");
      $finish;
   end

endmodule
